// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker module of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/bcc_pkg.sv =====
// Package with the codes, tables and widths of the commutation controller.
`timescale 1ns / 1ps
package bcc_pkg;

  localparam int SPINUP_DEPTH_DEF = 32;
  localparam int MaxOut           = 32;

  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [15:0] STALL_LIMIT_RST = 16'd1000;
  localparam logic [5:0]  SPINUP_STEPS_RST = 6'd0;

  // Request kinds.
  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_SENSOR = 2'd1;
  localparam logic [1:0] REQ_TABLE  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_STALL_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPINUP_STEPS = 2'd1;

  localparam logic [2:0] PHASE_OFF = 3'd6;

  // Gate pair codes: high side on, low side on, both off.
  localparam logic [1:0] PAIR_HIGH = 2'b00;
  localparam logic [1:0] PAIR_LOW  = 2'b11;
  localparam logic [1:0] PAIR_OFF  = 2'b10;

  function automatic logic [5:0] drive_of_phase(input logic [2:0] p);
    logic [5:0] d;
    case (p)
      3'd0:    d = {PAIR_OFF,  PAIR_LOW,  PAIR_LOW};
      3'd1:    d = {PAIR_HIGH, PAIR_OFF,  PAIR_LOW};
      3'd2:    d = {PAIR_HIGH, PAIR_HIGH, PAIR_OFF};
      3'd3:    d = {PAIR_OFF,  PAIR_HIGH, PAIR_HIGH};
      3'd4:    d = {PAIR_LOW,  PAIR_OFF,  PAIR_HIGH};
      3'd5:    d = {PAIR_LOW,  PAIR_LOW,  PAIR_OFF};
      default: d = {PAIR_OFF,  PAIR_OFF,  PAIR_OFF};
    endcase
    return d;
  endfunction

  // Sensor code ABC to phase; the two impossible codes give the off phase.
  function automatic logic [2:0] phase_of_code(input logic [2:0] code);
    logic [2:0] p;
    case (code)
      3'd0:    p = 3'd0;
      3'd1:    p = 3'd5;
      3'd3:    p = 3'd4;
      3'd4:    p = 3'd1;
      3'd6:    p = 3'd2;
      3'd7:    p = 3'd3;
      default: p = PHASE_OFF;
    endcase
    return p;
  endfunction

  // Next phase modulo six; stepping from the off phase lands on phase 1.
  function automatic logic [2:0] phase_advance(input logic [2:0] p);
    logic [2:0] n;
    case (p)
      3'd5:    n = 3'd0;
      3'd6:    n = 3'd1;
      3'd7:    n = 3'd2;
      default: n = p + 3'd1;
    endcase
    return n;
  endfunction

endpackage

// ===== rtl/bldc_commutation_controller.sv =====
// Six-step commutation controller with open-loop spinup, top level.
// Sensor change: SEND loads the result into the output register once it is free; a new item is taken after that.
// Tick: while running, accept and timers; in stall with no firing, accept, timers, read, compare.
// Each spinup firing goes through table read, compare, output load and step, in an order set by the
// single-port table read and the one shared compare unit; up to 32 per tick.
// rst_n is synchronous: the block restarts stalled, phase off, timers zero; no clearing pass.
`timescale 1ns / 1ps
module bldc_commutation_controller #(
  parameter int SPINUP_DEPTH = bcc_pkg::SPINUP_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input channel.
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // tdata, from bit 0: sensor_bits[2:0], table_index[7:3], table_value[23:8].
  input  logic [bcc_pkg::IN_DATA_W-1:0]  in_tdata,
  // tuser, from bit 0: req_type[1:0].
  input  logic [bcc_pkg::IN_USER_W-1:0]  in_tuser,
  // Result channel.
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // tdata, from bit 0: drive_word[5:0], phase_now[8:6], zero fill[15:9].
  output logic [bcc_pkg::OUT_DATA_W-1:0] out_tdata,
  // tuser, from bit 0: in_stall[0].
  output logic                           out_tuser,
  output logic                           out_tlast,
  // Configuration write channel.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bcc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bcc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bcc_pkg::*;

  // Address width of the spinup table; one bit at minimum.
  localparam int AW = (SPINUP_DEPTH > 1) ? $clog2(SPINUP_DEPTH) : 1;

  // Sequencer states. TICK updates the timers and checks for a stall, READ
  // fetches the table entry at spin_step, CMP decides whether it fires and
  // SEND loads the output register.
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_TICK = 5'b00010,
    S_READ = 5'b00100,
    S_CMP  = 5'b01000,
    S_SEND = 5'b10000
  } state_t;

  state_t      state_r, state_nxt;
  logic [2:0]  phase_r, phase_nxt;
  logic        stall_r, stall_nxt;
  logic [15:0] comm_r, comm_nxt;
  logic [15:0] spin_ticks_r, spin_ticks_nxt;
  logic [5:0]  spin_step_r, spin_step_nxt;
  logic [5:0]  fired_r, fired_nxt;
  logic        pend_r, pend_nxt;
  logic        send_last_r, send_last_nxt;
  logic        send_stall_r, send_stall_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [5:0]  out_drive_r;
  logic [2:0]  out_phase_r;
  logic        out_stall_r;
  logic        out_last_r;

  logic [15:0] stall_limit_r;
  logic [5:0]  spinup_steps_r;

  logic [15:0] spin_table [SPINUP_DEPTH];
  logic [15:0] rdata_r;

  logic [1:0]  req_type;
  logic [2:0]  sensor_bits;
  logic [4:0]  table_index;
  logic [15:0] table_value;
  logic        in_xfer;
  logic [15:0] comm_inc;
  logic [15:0] spin_inc;
  logic [15:0] cmp_a;
  logic [15:0] cmp_b;
  logic        cmp_ge;
  logic [6:0]  count;
  logic        step_lt;
  logic        fire;
  logic        out_free;
  logic        load_out;
  logic [6:0]  wr_ext;
  logic        wr_en;

  assign req_type    = in_tuser;
  assign sensor_bits = in_tdata[2:0];
  assign table_index = in_tdata[7:3];
  assign table_value = in_tdata[23:8];

  // Items are taken only while the sequencer rests; configuration is always taken.
  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Both timers saturate at full scale.
  assign comm_inc = (comm_r == 16'hFFFF) ? comm_r : comm_r + 16'd1;
  assign spin_inc = (spin_ticks_r == 16'hFFFF) ? spin_ticks_r : spin_ticks_r + 16'd1;

  // The one shared comparator. During TICK it tests the stall limit
  // (comm_ticks > limit is the same as not limit >= comm_ticks); during CMP it
  // tests whether the spin timer has reached the current table entry.
  always_comb begin
    if (state_r == S_TICK) begin
      cmp_a = stall_limit_r;
      cmp_b = comm_inc;
    end else begin
      cmp_a = spin_ticks_r;
      cmp_b = rdata_r;
    end
  end
  assign cmp_ge = (cmp_a >= cmp_b);

  // Entries in use, limited to the table depth.
  assign count   = ({1'b0, spinup_steps_r} > 7'(SPINUP_DEPTH)) ?
                   7'(SPINUP_DEPTH) : {1'b0, spinup_steps_r};
  assign step_lt = ({1'b0, spin_step_r} < count);
  assign fire    = (fired_r < 6'(MaxOut)) && step_lt && cmp_ge;

  // The output register is free when empty or being emptied in this cycle.
  assign out_free = !out_valid_r || out_tready;
  assign load_out = (state_r == S_SEND) && out_free;

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    stall_nxt      = stall_r;
    comm_nxt       = comm_r;
    spin_ticks_nxt = spin_ticks_r;
    spin_step_nxt  = spin_step_r;
    fired_nxt      = fired_r;
    pend_nxt       = pend_r;
    send_last_nxt  = send_last_r;
    send_stall_nxt = send_stall_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          case (req_type)
            REQ_TICK: begin
              state_nxt = S_TICK;
            end
            REQ_SENSOR: begin
              // Sensor changes are ignored while the motor is spinning up.
              if (!stall_r) begin
                comm_nxt       = 16'd0;
                phase_nxt      = phase_of_code(sensor_bits);
                send_last_nxt  = 1'b1;
                send_stall_nxt = 1'b0;
                state_nxt      = S_SEND;
              end
            end
            default: begin
              // Table writes are handled by the table itself; other kinds are dropped.
            end
          endcase
        end
      end
      S_TICK: begin
        comm_nxt       = comm_inc;
        spin_ticks_nxt = spin_inc;
        fired_nxt      = 6'd0;
        pend_nxt       = 1'b0;
        if (!stall_r && !cmp_ge) begin
          // Too long without a commutation: restart the spinup sequence.
          stall_nxt      = 1'b1;
          spin_ticks_nxt = 16'd0;
          spin_step_nxt  = 6'd0;
          state_nxt      = S_READ;
        end else if (stall_r) begin
          state_nxt = S_READ;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_READ: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (fire) begin
          if (pend_r) begin
            // Another word follows, so the held one goes out without last.
            // The compare result stays valid, so CMP fires again on return.
            send_last_nxt  = 1'b0;
            send_stall_nxt = 1'b1;
            pend_nxt       = 1'b0;
            state_nxt      = S_SEND;
          end else begin
            spin_step_nxt = spin_step_r + 6'd1;
            phase_nxt     = phase_advance(phase_r);
            fired_nxt     = fired_r + 6'd1;
            pend_nxt      = 1'b1;
            state_nxt     = S_READ;
          end
        end else begin
          if (!step_lt) begin
            // Table used up: back to closed-loop running.
            stall_nxt = 1'b0;
            comm_nxt  = 16'd0;
          end
          if (pend_r) begin
            send_last_nxt  = 1'b1;
            send_stall_nxt = 1'b1;
            pend_nxt       = 1'b0;
            state_nxt      = S_SEND;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_SEND: begin
        if (out_free) begin
          state_nxt = send_last_r ? S_IDLE : S_CMP;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      phase_r        <= PHASE_OFF;
      stall_r        <= 1'b1;
      comm_r         <= 16'd0;
      spin_ticks_r   <= 16'd0;
      spin_step_r    <= 6'd0;
      fired_r        <= 6'd0;
      pend_r         <= 1'b0;
      send_last_r    <= 1'b0;
      send_stall_r   <= 1'b0;
      out_valid_r    <= 1'b0;
      stall_limit_r  <= STALL_LIMIT_RST;
      spinup_steps_r <= SPINUP_STEPS_RST;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      stall_r      <= stall_nxt;
      comm_r       <= comm_nxt;
      spin_ticks_r <= spin_ticks_nxt;
      spin_step_r  <= spin_step_nxt;
      fired_r      <= fired_nxt;
      pend_r       <= pend_nxt;
      send_last_r  <= send_last_nxt;
      send_stall_r <= send_stall_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_STALL_LIMIT:  stall_limit_r  <= cfg_data;
          CFG_SPINUP_STEPS: spinup_steps_r <= cfg_data[5:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Output payload; it is only loaded from SEND, so it needs no reset.
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_drive_r <= drive_of_phase(phase_r);
      out_phase_r <= phase_r;
      out_stall_r <= send_stall_r;
      out_last_r  <= send_last_r;
    end
  end

  // Spinup table: one write port from the input channel, one registered read
  // at spin_step. Indexes at or beyond the depth are not written.
  assign wr_ext = {2'b00, table_index};
  assign wr_en  = in_xfer && (req_type == REQ_TABLE) && (wr_ext < 7'(SPINUP_DEPTH));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      spin_table[wr_ext[AW-1:0]] <= table_value;
    end
    if (state_r == S_READ) begin
      rdata_r <= spin_table[spin_step_r[AW-1:0]];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_phase_r, out_drive_r};
  assign out_tuser  = out_stall_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== rtl/bcc_checker.sv =====
// Port-level checker for the commutation controller, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bcc_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [bcc_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                           out_tuser,
  input logic                           out_tlast
);
  import bcc_pkg::*;

  logic [5:0]  out_drive;
  logic [2:0]  out_phase;
  logic [17:0] out_bus;

  assign out_drive = out_tdata[5:0];
  assign out_phase = out_tdata[8:6];
  assign out_bus   = {out_tlast, out_tuser, out_tdata};

  // A result that waits holds its payload.
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, $stable(out_bus))

  // While a burst of spinup words is under way, no new item is taken.
  `ASSERT_IMPLY(a_burst_blocks_input, clk, rst_n, out_tvalid && !out_tlast, !in_tready)

  // The gate word always matches the phase reported beside it.
  `ASSERT_IMPLY(a_drive_matches_phase, clk, rst_n, out_tvalid, out_drive == drive_of_phase(out_phase))

  // A sensor commutation is a single word.
  `ASSERT_IMPLY(a_sensor_single, clk, rst_n, out_tvalid && !out_tuser, out_tlast)

  // Spinup never drives the off phase.
  `ASSERT_IMPLY(a_spin_phase, clk, rst_n, out_tvalid && out_tuser, out_phase != PHASE_OFF)

endmodule

bind bldc_commutation_controller bcc_checker u_bcc_checker (.*);
